@@ design/bbc_pkg.sv @@
// bbc_pkg: shared constants, types and helpers for the clamped-edge box blur
// used by box_blur_clamped_edges and bbc_div; no dependencies
package bbc_pkg;

	localparam int MAX_KERNEL   = 15;
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 4;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int STORE_DEPTH  = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;

	localparam int AW      = $clog2(STORE_DEPTH);   // store address bits
	localparam int KW      = 4;                      // kernel_size bits
	localparam int DIMW    = 11;                     // width/height register bits
	localparam int CW      = 3;                      // channel_count bits
	localparam int CRDW    = 10;                     // coordinate bits
	localparam int POSW    = 23;                     // frame position, holds the frame size
	localparam int LINW    = 22;                     // linear sample index
	localparam int SUMW    = 16;                     // window sum
	localparam int KKW     = 8;                      // kernel area
	localparam int LAGW    = 15;
	localparam int LOWW    = 12;                     // store depth is 15 * 2^12

	typedef enum logic [1:0] {
		REG_KERNEL   = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2,
		REG_CHANNELS = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GEN,
		ST_DRAIN,
		ST_DIVGO,
		ST_DIV,
		ST_PUSH
	} state_t;

	// store address of a linear index: index mod (15 * 4096)
	// upper part mod 15 through hex digit sum, since 16 is 1 mod 15
	function automatic logic [AW-1:0] store_addr(input logic [LINW-1:0] lin);
		logic [5:0] s;
		logic [3:0] r;
		s = 6'(lin[LOWW+3:LOWW]) + 6'(lin[LOWW+7:LOWW+4]) + 6'(lin[LINW-1:LOWW+8]);
		if (s >= 6'd30)
			r = 4'(s - 6'd30);
		else if (s >= 6'd15)
			r = 4'(s - 6'd15);
		else
			r = s[3:0];
		return {r, lin[LOWW-1:0]};
	endfunction

endpackage

@@ design/bbc_div.sv @@
// bbc_div: restoring divider, one quotient bit per cycle, window sum by kernel area
// depends on bbc_pkg
module bbc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bbc_pkg::SUMW-1:0]  dividend,
	input  logic [bbc_pkg::KKW-1:0]   divisor,
	output logic                      done,
	output logic [7:0]                quotient
);
	import bbc_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [4:0]      cnt_q;
	logic [KKW-1:0]  rem_q;
	logic [SUMW-1:0] quo_q;
	logic [KKW:0]    trial;
	logic            fits;

	assign trial = {rem_q, quo_q[SUMW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(SUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? KKW'(trial - {1'b0, divisor}) : trial[KKW-1:0];
			quo_q <= {quo_q[SUMW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[7:0];

endmodule

@@ design/box_blur_clamped_edges.sv @@
// box_blur_clamped_edges: streaming k x k mean blur, clamp-to-edge, one sample store
// flow: an accepted beat is checked for emission; an emitting one reads its window, one sample
// per cycle from the single read port of the store, then serially divides the window sum; the
// block takes one item at a time and holds off input until the result is in the output register
// reset: registers to 3/640/480/3, positions zero; input held off after reset
// or a register write while frame sizes are recomputed; store contents are not cleared
module box_blur_clamped_edges (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [bbc_pkg::DIMW-1:0]   cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [7:0]                 sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 blurred,
	output logic                       frame_end
);
	import bbc_pkg::*;

	// configuration
	logic [KW-1:0]   kernel_q;
	logic [DIMW-1:0] width_q, height_q;
	logic [CW-1:0]   chan_q;
	logic [KW-1:0]   ek, eb, ef;
	logic [DIMW-1:0] ew, eh;
	logic [CW-1:0]   ec;
	logic [20:0]     wh_q;
	logic [12:0]     fw_q;
	logic [KKW-1:0]  kk_q;
	logic [POSW-1:0] total_q;
	logic [LAGW-1:0] lag_q;
	logic [1:0]      settle_q;

	// positions
	logic [POSW-1:0] in_pos_q, out_pos_q;
	logic [AW-1:0]   wptr_q;
	logic [1:0]      och_q;
	logic [CRDW-1:0] ox_q, oy_q;

	// control
	state_t state_q, state_d;
	logic   accept, wr_en, emit, gen_en, gen_last, div_start, load_out, last_out;
	logic   div_done;
	logic [7:0] div_quo;

	// window walk and read pipeline
	logic [KW-1:0]    dy_q, dx_q;
	logic signed [12:0] yy_t, xx_t;
	logic [CRDW-1:0]  yy_c, xx_c;
	logic             v_s1, last_s1, v_s2, last_s2, v_s3, last_s3, v_s4, last_s4;
	logic [CRDW-1:0]  yy_s1, xx_s1;
	logic [1:0]       ch_s1, ch_s2;
	logic [19:0]      lin_s2;
	logic [LINW-1:0]  lin_s3;
	logic [7:0]       rdata_s4;
	logic [SUMW-1:0]  sum_q;
	logic             out_valid_q, frame_end_q;
	logic [7:0]       blurred_q;

	logic [7:0] store_mem [STORE_DEPTH];

	// out-of-range registers act as the nearest legal value
	always_comb begin
		ek = (kernel_q == '0) ? KW'(1) : kernel_q;
		ew = (width_q == '0) ? DIMW'(1) : (width_q > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH) : width_q;
		eh = (height_q == '0) ? DIMW'(1)
			: (height_q > DIMW'(HEIGHT_LIMIT)) ? DIMW'(HEIGHT_LIMIT) : height_q;
		ec = (chan_q == '0) ? CW'(1) : (chan_q > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : chan_q;
		eb = ek >> 1;
		ef = ek - KW'(1) - eb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KW'(3);
			width_q  <= DIMW'(640);
			height_q <= DIMW'(480);
			chan_q   <= CW'(3);
			settle_q <= 2'd3;
		end else begin
			if (cfg_we) begin
				settle_q <= 2'd3;
				unique case (reg_index_t'(cfg_index))
					REG_KERNEL:   kernel_q <= cfg_data[KW-1:0];
					REG_WIDTH:    width_q  <= cfg_data;
					REG_HEIGHT:   height_q <= cfg_data;
					REG_CHANNELS: chan_q   <= cfg_data[CW-1:0];
					default: ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// frame size and lag, two register steps behind the registers
	always_ff @(posedge clk) begin
		wh_q    <= 21'(ew * eh);
		fw_q    <= 13'(ef * ew) + 13'(ef);
		kk_q    <= KKW'(ek * ek);
		total_q <= POSW'(wh_q * ec);
		lag_q   <= LAGW'(fw_q * ec);
	end

	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && !req_type && (in_pos_q < total_q);
	assign emit     = ((in_pos_q - out_pos_q) > POSW'(lag_q)) || (in_pos_q >= total_q);
	assign gen_last = (dy_q == ek - KW'(1)) && (dx_q == ek - KW'(1));
	assign last_out = (out_pos_q + POSW'(1)) == total_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_CHECK;
			ST_CHECK: state_d = emit ? ST_GEN : ST_IDLE;
			ST_GEN:   if (gen_last) state_d = ST_DRAIN;
			ST_DRAIN: if (v_s4 && last_s4) state_d = ST_DIVGO;
			ST_DIVGO: state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_PUSH;
			ST_PUSH:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE) && (settle_q == 2'd0);
		gen_en    = (state_q == ST_GEN);
		div_start = (state_q == ST_DIVGO);
		load_out  = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_pos_q    <= '0;
			out_pos_q   <= '0;
			wptr_q      <= '0;
			och_q       <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= gen_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			if (state_q == ST_CHECK) begin
				dy_q <= '0;
				dx_q <= '0;
			end else if (gen_en) begin
				if (dx_q == ek - KW'(1)) begin
					dx_q <= '0;
					dy_q <= dy_q + KW'(1);
				end else begin
					dx_q <= dx_q + KW'(1);
				end
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cfg_we || (load_out && last_out)) begin
				in_pos_q  <= '0;
				out_pos_q <= '0;
				wptr_q    <= '0;
				och_q     <= '0;
				ox_q      <= '0;
				oy_q      <= '0;
			end else begin
				if (wr_en) begin
					in_pos_q <= in_pos_q + POSW'(1);
					wptr_q   <= (wptr_q == AW'(STORE_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
				end
				if (load_out) begin
					out_pos_q <= out_pos_q + POSW'(1);
					if (3'(och_q) + 3'd1 == ec) begin
						och_q <= '0;
						if (DIMW'(ox_q) + DIMW'(1) == ew) begin
							ox_q <= '0;
							oy_q <= oy_q + CRDW'(1);
						end else begin
							ox_q <= ox_q + CRDW'(1);
						end
					end else begin
						och_q <= och_q + 2'd1;
					end
				end
			end
		end
	end

	// clamp window coordinates to the image
	always_comb begin
		yy_t = $signed({3'b0, oy_q}) + $signed({9'b0, dy_q}) - $signed({9'b0, eb});
		xx_t = $signed({3'b0, ox_q}) + $signed({9'b0, dx_q}) - $signed({9'b0, eb});
		if (yy_t < 0)
			yy_c = '0;
		else if (yy_t > $signed({2'b0, eh}) - 13'sd1)
			yy_c = CRDW'(eh - DIMW'(1));
		else
			yy_c = yy_t[CRDW-1:0];
		if (xx_t < 0)
			xx_c = '0;
		else if (xx_t > $signed({2'b0, ew}) - 13'sd1)
			xx_c = CRDW'(ew - DIMW'(1));
		else
			xx_c = xx_t[CRDW-1:0];
	end

	always_ff @(posedge clk) begin
		yy_s1    <= yy_c;
		xx_s1    <= xx_c;
		ch_s1    <= och_q;
		last_s1  <= gen_last;
		lin_s2   <= 20'(yy_s1 * ew) + 20'(xx_s1);
		ch_s2    <= ch_s1;
		last_s2  <= last_s1;
		lin_s3   <= LINW'(lin_s2 * ec) + LINW'(ch_s2);
		last_s3  <= last_s2;
		last_s4  <= last_s3;
		if (state_q == ST_CHECK)
			sum_q <= '0;
		else if (v_s4)
			sum_q <= sum_q + SUMW'(rdata_s4);
		if (load_out) begin
			blurred_q   <= div_quo;
			frame_end_q <= last_out;
		end
	end

	// sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			store_mem[wptr_q] <= sample;
		rdata_s4 <= store_mem[store_addr(lin_s3)];
	end

	bbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (kk_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign blurred   = blurred_q;
	assign frame_end = frame_end_q;

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CHECK)
		else $error("accepted beat not followed by emission check");

	a_write_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q < AW'(STORE_DEPTH))
		else $error("store write pointer out of range");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !in_ready)
		else $error("input taken while window reads in flight");

	a_out_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(settle_q == 2'd0 && state_q == ST_IDLE) |-> out_pos_q <= in_pos_q)
		else $error("output position ahead of input position");

endmodule

@@ verif/tb_box_blur_clamped_edges.sv @@
// tb_box_blur_clamped_edges: self-checking bench for the clamped-edge box blur
// depends on bbc_pkg and box_blur_clamped_edges; predicts every result in-bench
module tb_box_blur_clamped_edges;
	import bbc_pkg::*;

	typedef struct {
		logic       drain;
		logic [7:0] smp;
	} blur_req_t;

	typedef struct {
		logic [7:0] mean;
		logic       last;
	} blur_res_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [DIMW-1:0]     cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                req_type;
	logic [7:0]          sample;
	logic                out_valid;
	logic                out_ready;
	logic [7:0]          blurred;
	logic                frame_end;

	box_blur_clamped_edges dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .blurred(blurred),
		.frame_end(frame_end)
	);

	// predictor state
	logic [7:0]  pix_mem [0:STORE_DEPTH-1];
	int unsigned k_reg = 3, w_reg = 640, h_reg = 480, c_reg = 3;
	int unsigned in_pos = 0, out_pos = 0;

	blur_req_t   pending_beats[$];
	blur_res_t   expected_means[$];
	int          fails = 0;
	int          cyc = 0;
	int          beats_sent = 0;

	function automatic int unsigned clampv(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned reach_fwd();
		int unsigned k;
		k = clampv(k_reg, MAX_KERNEL);
		return k - 1 - k / 2;
	endfunction

	function automatic int unsigned frame_size();
		return clampv(w_reg, MAX_WIDTH) * clampv(h_reg, HEIGHT_LIMIT)
			* clampv(c_reg, MAX_CHANNELS);
	endfunction

	function automatic int unsigned lag_len();
		int unsigned f;
		f = reach_fwd();
		return (f * clampv(w_reg, MAX_WIDTH) + f) * clampv(c_reg, MAX_CHANNELS);
	endfunction

	function automatic logic [7:0] box_mean(int unsigned o);
		int unsigned k, w, h, c, ch, pix, sum, idx;
		int x, y, b, f, yy, xx;
		k = clampv(k_reg, MAX_KERNEL);
		w = clampv(w_reg, MAX_WIDTH);
		h = clampv(h_reg, HEIGHT_LIMIT);
		c = clampv(c_reg, MAX_CHANNELS);
		ch = o % c;
		pix = o / c;
		x = pix % w;
		y = pix / w;
		b = k / 2;
		f = k - 1 - b;
		sum = 0;
		for (int dy = -b; dy <= f; dy++) begin
			yy = y + dy;
			if (yy < 0) yy = 0;
			if (yy > int'(h) - 1) yy = h - 1;
			for (int dx = -b; dx <= f; dx++) begin
				xx = x + dx;
				if (xx < 0) xx = 0;
				if (xx > int'(w) - 1) xx = w - 1;
				idx = ((yy * w + xx) * c + ch) % STORE_DEPTH;
				sum += pix_mem[idx];
			end
		end
		return 8'(sum / (k * k));
	endfunction

	function automatic void predict_blur(blur_req_t r);
		int unsigned total;
		blur_res_t e;
		total = frame_size();
		if (!r.drain && in_pos < total) begin
			pix_mem[in_pos % STORE_DEPTH] = r.smp;
			in_pos++;
		end
		if (out_pos >= total) return;
		if (!(in_pos - out_pos > lag_len() || in_pos >= total)) return;
		e.mean = box_mean(out_pos);
		e.last = (out_pos + 1 == total);
		expected_means.push_back(e);
		out_pos++;
		if (e.last) begin
			in_pos = 0;
			out_pos = 0;
		end
	endfunction

	// clock and cycle count
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// no idling on either side inside this window
	wire quiet = (cyc > 30000 && cyc < 45000);

	// driver
	always @(posedge clk or negedge arst_n) begin
		blur_req_t nx;
		logic      take;
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= 1'b0;
			sample   <= 8'd0;
		end else begin
			take = in_valid && in_ready;
			if (take) begin
				predict_blur(pending_beats.pop_front());
				beats_sent++;
			end
			if (!in_valid || take) begin
				if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
					nx = pending_beats[0];
					in_valid <= 1'b1;
					req_type <= nx.drain;
					sample   <= nx.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off so the block backs up
	int holdoff = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (cyc == 20000) holdoff = 5000;
			if (holdoff > 0) begin
				holdoff = holdoff - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 31;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		blur_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_means.size() == 0) begin
				$display("%0t: unexpected beat blurred=%0d frame_end=%0b",
					$time, blurred, frame_end);
				fails++;
			end else begin
				e = expected_means.pop_front();
				if (blurred !== e.mean) begin
					$display("%0t: blurred expected %0d actual %0d", $time, e.mean, blurred);
					fails++;
				end
				if (frame_end !== e.last) begin
					$display("%0t: frame_end expected %0b actual %0b",
						$time, e.last, frame_end);
					fails++;
				end
			end
		end
	end

	task automatic settle();
		while (pending_beats.size() > 0 || in_valid || expected_means.size() > 0)
			@(posedge clk);
		// an item with no result may still be in flight
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= DIMW'(val);
		case (idx)
			REG_KERNEL:   k_reg = val & 4'hF;
			REG_WIDTH:    w_reg = val & 11'h7FF;
			REG_HEIGHT:   h_reg = val & 11'h7FF;
			REG_CHANNELS: c_reg = val & 3'h7;
		endcase
		in_pos = 0;
		out_pos = 0;
	endtask

	task automatic set_geometry(int unsigned k, int unsigned w, int unsigned h, int unsigned c);
		settle();
		write_reg(REG_KERNEL, k);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_CHANNELS, c);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// nsamp < 0 queues a whole frame with its flush tail
	task automatic queue_frame(int nsamp);
		blur_req_t r;
		int unsigned total, tail;
		total = frame_size();
		tail = lag_len() < total ? lag_len() : total;
		if (nsamp < 0) nsamp = total;
		for (int i = 0; i < nsamp; i++) begin
			// stray drains before input completes do nothing
			if ($urandom_range(19) == 0) begin
				r.drain = 1'b1;
				r.smp = 8'($urandom_range(255));
				pending_beats.push_back(r);
			end
			r.drain = 1'b0;
			r.smp = pick_sample();
			pending_beats.push_back(r);
		end
		if (nsamp == int'(total))
			for (int i = 0; i < int'(tail); i++) begin
				// a sample past the frame's last one is ignored like a drain
				r.drain = $urandom_range(1);
				r.smp = 8'($urandom_range(255));
				pending_beats.push_back(r);
			end
	endtask

	initial begin
		int unsigned k, w, h, c;
		cfg_we    = 1'b0;
		cfg_index = REG_KERNEL;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset geometry, then extremes and out-of-range registers
		queue_frame(3);
		set_geometry(1, 1, 1, 1);
		queue_frame(-1);
		set_geometry(0, 0, 0, 0);
		queue_frame(-1);
		set_geometry(15, 2, 2, 4);
		queue_frame(-1);
		set_geometry(2, 2047, 1, 7);
		queue_frame(6);
		set_geometry(1, 1, 2047, 5);
		queue_frame(5);
		set_geometry(4, 1024, 1024, 4);
		queue_frame(3);

		// random geometries, mostly whole frames
		while (beats_sent + pending_beats.size() < 950) begin
			k = $urandom_range(15);
			w = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
			h = $urandom_range(6);
			c = $urandom_range(7);
			set_geometry(k, w, h, c);
			repeat ($urandom_range(1, 3))
				if (beats_sent + pending_beats.size() < 950)
					queue_frame($urandom_range(5) == 0 ? int'($urandom_range(frame_size()))
						: -1);
		end

		settle();
		if (fails == 0)
			$display("box_blur_clamped_edges test passed");
		else
			$display("box_blur_clamped_edges test failed");
		$finish;
	end

	initial begin
		#12000000;
		$display("box_blur_clamped_edges test failed");
		$finish;
	end

endmodule
